// File: rtl/boot_option_priority_selector_core_defines.svh
// Assertion macros for the boot option priority selector.
// Expects clk and rst_n (synchronous, active low) in the module that uses them.
`ifndef BOOT_OPTION_PRIORITY_SELECTOR_CORE_DEFINES_SVH
`define BOOT_OPTION_PRIORITY_SELECTOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define BOPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BOPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bops_pkg.sv
// Shared types, codes and helpers for the boot option priority selector.
// No dependencies; used by bops_unit and the top level.
`timescale 1ns / 1ps

package bops_pkg;

  // default sizes of the slot table and the order list
  localparam int SLOTS_DEF       = 16;
  localparam int ORDER_DEPTH_DEF = 16;

  // field widths
  localparam int NUM_W    = 16;
  localparam int REQ_W    = 3;
  localparam int REASON_W = 3;
  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 24;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ORDER  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_NEXT   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SELECT = 3'd4;

  // select reason codes
  localparam logic [REASON_W-1:0] RSN_NEXT   = 3'd0;
  localparam logic [REASON_W-1:0] RSN_ORDER  = 3'd1;
  localparam logic [REASON_W-1:0] RSN_SETUP  = 3'd2;
  localparam logic [REASON_W-1:0] RSN_EMPTY  = 3'd3;
  localparam logic [REASON_W-1:0] RSN_FAILED = 3'd4;

  // per-slot attributes kept in RAM; the valid bit lives in flops
  typedef struct packed {
    logic path;
    logic hidden;
    logic active;
  } attr_t;

  // compare unit results
  typedef struct packed {
    logic in_range;
    logic eq;
  } chk_t;

  // bootable once the slot is known valid
  function automatic logic attr_ok(attr_t a);
    return a.active & ~a.hidden & a.path;
  endfunction

endpackage

// File: rtl/bops_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bops_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/bops_unit.sv
// Shared option-number compare unit: range check, slot index and match.
// Depends on bops_pkg.
`timescale 1ns / 1ps

module bops_unit #(
  parameter int SLOTS = bops_pkg::SLOTS_DEF,
  localparam int SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic [bops_pkg::NUM_W-1:0] num,
  input  logic [bops_pkg::NUM_W-1:0] target,
  output bops_pkg::chk_t             chk,
  output logic [SAW-1:0]             slot
);

  import bops_pkg::*;

  logic [NUM_W-1:0] num_m1;

  // option n names slot n-1; zero and anything past the table are out of range
  assign num_m1       = num - NUM_W'(1);
  assign slot         = num_m1[SAW-1:0];
  assign chk.in_range = (num != '0) && ({1'b0, num} <= (NUM_W + 1)'(SLOTS));
  assign chk.eq       = (num == target);

endmodule

// File: rtl/boot_option_priority_selector_core.sv
// Top level of the boot option priority selector: sequencer, slot valid bits,
// order list and slot attribute RAMs. Depends on bops_pkg, bops_ram, bops_unit.
//
//   port group  | dir | carries
//   ------------+-----+-------------------------------------------------
//   in_*        | in  | request beat: type in tuser, operands in tdata
//   out_*       | out | result beat: status, option, reason, menu flag
//
// One request at a time; in_tready is high only while the sequencer idles.
// Add walks the slot valid bits one per cycle until it finds a free slot.
// Select walks the order list only when boot-next does not qualify, with the
// order RAM read and attribute RAM read overlapped, one entry per cycle.
// Remove frees the slot, then searches the order list and shifts it to close the gap.
// The result register frees the sequencer; a stalled out_tready holds the
// next result in the sequencer until the register drains.
`timescale 1ns / 1ps
`include "boot_option_priority_selector_core_defines.svh"

module boot_option_priority_selector_core #(
  parameter int SLOTS       = bops_pkg::SLOTS_DEF,
  parameter int ORDER_DEPTH = bops_pkg::ORDER_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // opt_num[15:0], attr_active, attr_hidden, path_present,
  // order_first, setup_key, menu_key, zero pad
  input  logic [bops_pkg::IN_DW-1:0]  in_tdata,
  // req_type
  input  logic [bops_pkg::REQ_W-1:0]  in_tuser,
  // order_last
  input  logic                        in_tlast,
  // result channel
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // status, chosen_option[15:0], select_reason[2:0], menu_flag, zero pad
  output logic [bops_pkg::OUT_DW-1:0] out_tdata
);

  import bops_pkg::*;

  localparam int SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OAW = (ORDER_DEPTH > 1) ? $clog2(ORDER_DEPTH) : 1;
  localparam int OCW = $clog2(ORDER_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_RM_CHECK,
    ST_RM_FIND,
    ST_RM_SHIFT,
    ST_ORD_WR,
    ST_SEL_START,
    ST_SEL_NEXT,
    ST_SEL_WALK,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // latched request
  logic [NUM_W-1:0] num_r, num_nxt;
  logic             act_r, act_nxt, hid_r, hid_nxt, path_r, path_nxt;
  logic             first_r, first_nxt, setup_r, setup_nxt, mkey_r, mkey_nxt;

  // architectural state
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [OCW-1:0]   count_r, count_nxt;
  logic [NUM_W-1:0] next_r, next_nxt;
  logic             menu_r, menu_nxt;

  // walk counters and pipeline
  logic [SAW-1:0]   scan_r, scan_nxt;
  logic [OCW-1:0]   idx_r, idx_nxt;
  logic             p1_vld_r, p1_vld_nxt, p1_last_r, p1_last_nxt;
  logic [OCW-1:0]   p1_pos_r, p1_pos_nxt;
  logic             p2_vld_r, p2_vld_nxt, p2_last_r, p2_last_nxt;
  logic             p2_ok_r, p2_ok_nxt, nb_ok_r, nb_ok_nxt;
  logic [NUM_W-1:0] p2_num_r, p2_num_nxt;

  // pending result and output register
  logic                res_status_r, res_status_nxt;
  logic [NUM_W-1:0]    res_chosen_r, res_chosen_nxt;
  logic [REASON_W-1:0] res_reason_r, res_reason_nxt;
  logic                out_vld_r, out_vld_nxt, out_status_r, out_status_nxt;
  logic [NUM_W-1:0]    out_chosen_r, out_chosen_nxt;
  logic [REASON_W-1:0] out_reason_r, out_reason_nxt;
  logic                out_menu_r, out_menu_nxt;

  // RAM ports and compare unit
  logic             ord_we;
  logic [OAW-1:0]   ord_waddr, ord_raddr;
  logic [NUM_W-1:0] ord_wdata, ord_rdata;
  logic             attr_we;
  attr_t            attr_wdata, attr_rdata;
  logic [NUM_W-1:0] u_num;
  chk_t             chk;
  logic [SAW-1:0]   u_slot;

  logic           in_acc, walk_more, walk_last;
  logic [OCW-1:0] cnt_eff, pos_m1;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign walk_more = (idx_r < count_r);
  assign walk_last = (idx_r == count_r - OCW'(1));
  assign cnt_eff   = first_r ? '0 : count_r;
  assign pos_m1    = p1_pos_r - OCW'(1);

  // compare unit operand select
  always_comb begin
    case (state_r)
      ST_RM_CHECK:  u_num = num_r;
      ST_SEL_START: u_num = next_r;
      default:      u_num = ord_rdata;
    endcase
  end

  bops_unit #(.SLOTS(SLOTS)) u_unit (
    .num    (u_num),
    .target (num_r),
    .chk    (chk),
    .slot   (u_slot)
  );

  bops_ram #(.WIDTH(NUM_W), .DEPTH(ORDER_DEPTH)) u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  bops_ram #(.WIDTH($bits(attr_t)), .DEPTH(SLOTS)) u_attr_ram (
    .clk   (clk),
    .we    (attr_we),
    .waddr (scan_r),
    .wdata (attr_wdata),
    .raddr (u_slot),
    .rdata (attr_rdata)
  );

  assign attr_wdata = '{path: path_r, hidden: hid_r, active: act_r};

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    num_nxt        = num_r;
    act_nxt        = act_r;
    hid_nxt        = hid_r;
    path_nxt       = path_r;
    first_nxt      = first_r;
    setup_nxt      = setup_r;
    mkey_nxt       = mkey_r;
    valid_nxt      = valid_r;
    count_nxt      = count_r;
    next_nxt       = next_r;
    menu_nxt       = menu_r;
    scan_nxt       = scan_r;
    idx_nxt        = idx_r;
    p1_vld_nxt     = 1'b0;
    p1_last_nxt    = p1_last_r;
    p1_pos_nxt     = p1_pos_r;
    p2_vld_nxt     = 1'b0;
    p2_last_nxt    = p2_last_r;
    p2_ok_nxt      = p2_ok_r;
    p2_num_nxt     = p2_num_r;
    nb_ok_nxt      = nb_ok_r;
    res_status_nxt = res_status_r;
    res_chosen_nxt = res_chosen_r;
    res_reason_nxt = res_reason_r;
    out_vld_nxt    = out_vld_r;
    out_status_nxt = out_status_r;
    out_chosen_nxt = out_chosen_r;
    out_reason_nxt = out_reason_r;
    out_menu_nxt   = out_menu_r;
    ord_we         = 1'b0;
    ord_waddr      = idx_r[OAW-1:0];
    ord_wdata      = num_r;
    ord_raddr      = idx_r[OAW-1:0];
    attr_we        = 1'b0;

    // output register drains on its own
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          num_nxt        = in_tdata[15:0];
          act_nxt        = in_tdata[16];
          hid_nxt        = in_tdata[17];
          path_nxt       = in_tdata[18];
          first_nxt      = in_tdata[19];
          setup_nxt      = in_tdata[20];
          mkey_nxt       = in_tdata[21];
          res_status_nxt = 1'b0;
          res_chosen_nxt = '0;
          res_reason_nxt = RSN_NEXT;
          scan_nxt       = '0;
          idx_nxt        = '0;
          case (in_tuser)
            REQ_ADD:    state_nxt = ST_ADD_SCAN;
            REQ_REMOVE: state_nxt = ST_RM_CHECK;
            REQ_ORDER:  state_nxt = ST_ORD_WR;
            REQ_NEXT: begin
              next_nxt  = in_tdata[15:0];
              state_nxt = ST_EMIT;
            end
            REQ_SELECT: state_nxt = ST_SEL_START;
            default: begin
              res_status_nxt = 1'b1;
              state_nxt      = ST_EMIT;
            end
          endcase
        end
      end

      // first free slot, one per cycle
      ST_ADD_SCAN: begin
        if (!valid_r[scan_r]) begin
          attr_we           = 1'b1;
          valid_nxt[scan_r] = 1'b1;
          res_chosen_nxt    = NUM_W'(scan_r) + NUM_W'(1);
          state_nxt         = ST_EMIT;
        end else if (scan_r == SAW'(SLOTS - 1)) begin
          res_status_nxt = 1'b1;
          state_nxt      = ST_EMIT;
        end else begin
          scan_nxt = scan_r + SAW'(1);
        end
      end

      // option must exist; free its slot
      ST_RM_CHECK: begin
        if (!(chk.in_range && valid_r[u_slot])) begin
          res_status_nxt = 1'b1;
          state_nxt      = ST_EMIT;
        end else begin
          valid_nxt[u_slot] = 1'b0;
          idx_nxt           = '0;
          state_nxt         = (count_r == '0) ? ST_EMIT : ST_RM_FIND;
        end
      end

      // search the order list for the first entry naming the option
      ST_RM_FIND: begin
        if (walk_more) begin
          p1_vld_nxt  = 1'b1;
          p1_last_nxt = walk_last;
          p1_pos_nxt  = idx_r;
          idx_nxt     = idx_r + OCW'(1);
        end
        if (p1_vld_r) begin
          if (chk.eq) begin
            idx_nxt    = p1_pos_r + OCW'(1);
            p1_vld_nxt = 1'b0;
            state_nxt  = ST_RM_SHIFT;
          end else if (p1_last_r) begin
            p1_vld_nxt = 1'b0;
            state_nxt  = ST_EMIT;
          end
        end
      end

      // close the gap: read entry k, write it back at k-1 in the following cycle
      ST_RM_SHIFT: begin
        if (walk_more) begin
          p1_vld_nxt = 1'b1;
          p1_pos_nxt = idx_r;
          idx_nxt    = idx_r + OCW'(1);
        end
        if (p1_vld_r) begin
          ord_we    = 1'b1;
          ord_waddr = pos_m1[OAW-1:0];
          ord_wdata = ord_rdata;
        end
        if (!walk_more && !p1_vld_r) begin
          count_nxt = count_r - OCW'(1);
          state_nxt = ST_EMIT;
        end
      end

      // append one order entry (order_first restarts the list), entries past capacity dropped
      ST_ORD_WR: begin
        if (cnt_eff < OCW'(ORDER_DEPTH)) begin
          ord_we    = 1'b1;
          ord_waddr = cnt_eff[OAW-1:0];
          count_nxt = cnt_eff + OCW'(1);
        end else begin
          count_nxt = cnt_eff;
        end
        state_nxt = ST_EMIT;
      end

      // hotkeys, then look up the boot-next slot
      ST_SEL_START: begin
        if (mkey_r) begin
          menu_nxt = 1'b1;
        end
        if (setup_r) begin
          res_reason_nxt = RSN_SETUP;
          state_nxt      = ST_EMIT;
        end else begin
          nb_ok_nxt = chk.in_range && valid_r[u_slot];
          state_nxt = ST_SEL_NEXT;
        end
      end

      ST_SEL_NEXT: begin
        if (nb_ok_r && attr_ok(attr_rdata)) begin
          res_chosen_nxt = next_r;
          res_reason_nxt = RSN_NEXT;
          state_nxt      = ST_EMIT;
        end else if (count_r == '0) begin
          res_reason_nxt = RSN_EMPTY;
          state_nxt      = ST_EMIT;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_SEL_WALK;
        end
      end

      // order walk: list read, attribute read, check; one entry per cycle
      ST_SEL_WALK: begin
        if (walk_more) begin
          p1_vld_nxt  = 1'b1;
          p1_last_nxt = walk_last;
          idx_nxt     = idx_r + OCW'(1);
        end
        p2_vld_nxt  = p1_vld_r;
        p2_last_nxt = p1_last_r;
        p2_num_nxt  = ord_rdata;
        p2_ok_nxt   = chk.in_range && valid_r[u_slot];
        if (p2_vld_r) begin
          if (p2_ok_r && attr_ok(attr_rdata)) begin
            res_chosen_nxt = p2_num_r;
            res_reason_nxt = RSN_ORDER;
            p1_vld_nxt     = 1'b0;
            p2_vld_nxt     = 1'b0;
            state_nxt      = ST_EMIT;
          end else if (p2_last_r) begin
            res_reason_nxt = RSN_FAILED;
            p1_vld_nxt     = 1'b0;
            p2_vld_nxt     = 1'b0;
            state_nxt      = ST_EMIT;
          end
        end
      end

      // hand the result to the output register
      ST_EMIT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = res_status_r;
          out_chosen_nxt = res_chosen_r;
          out_reason_nxt = res_reason_r;
          out_menu_nxt   = menu_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      valid_r   <= '0;
      count_r   <= '0;
      next_r    <= '0;
      menu_r    <= 1'b0;
      p1_vld_r  <= 1'b0;
      p2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      count_r   <= count_nxt;
      next_r    <= next_nxt;
      menu_r    <= menu_nxt;
      p1_vld_r  <= p1_vld_nxt;
      p2_vld_r  <= p2_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    num_r        <= num_nxt;
    act_r        <= act_nxt;
    hid_r        <= hid_nxt;
    path_r       <= path_nxt;
    first_r      <= first_nxt;
    setup_r      <= setup_nxt;
    mkey_r       <= mkey_nxt;
    scan_r       <= scan_nxt;
    idx_r        <= idx_nxt;
    p1_last_r    <= p1_last_nxt;
    p1_pos_r     <= p1_pos_nxt;
    p2_last_r    <= p2_last_nxt;
    p2_ok_r      <= p2_ok_nxt;
    p2_num_r     <= p2_num_nxt;
    nb_ok_r      <= nb_ok_nxt;
    res_status_r <= res_status_nxt;
    res_chosen_r <= res_chosen_nxt;
    res_reason_r <= res_reason_nxt;
    out_status_r <= out_status_nxt;
    out_chosen_r <= out_chosen_nxt;
    out_reason_r <= out_reason_nxt;
    out_menu_r   <= out_menu_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_menu_r, out_reason_r, out_chosen_r, out_status_r};

  // checks
  `BOPS_ASSERT_NEXT(a_busy_after_beat, in_acc, !in_tready, "ready after accepted beat")
  `BOPS_ASSERT_SAME(a_count_bound, 1'b1, count_r <= OCW'(ORDER_DEPTH), "order count overflow")
  `BOPS_ASSERT_NEXT(a_menu_sticky, menu_r, menu_r, "menu flag cleared")
  `BOPS_ASSERT_SAME(a_walk_pipe, p2_vld_r, state_r == ST_SEL_WALK, "walk stage live outside walk")
  `BOPS_ASSERT_SAME(a_order_pick, out_vld_r && out_reason_r == RSN_ORDER, out_chosen_r != '0,
                    "order pick without option")

endmodule
